/* rtl/tsp_pkg.sv */
// Shared types and constants for the touch slider position tracker.
// No dependencies; every other file takes names from here by scope.
`timescale 1ns / 1ps

package tsp_pkg;

    localparam int CHANNELS      = 4;
    localparam int SAMPLE_BITS   = 16;
    localparam int LANE_W        = 16;
    localparam int SCALE         = 1000;
    localparam int WEIGHT_OFFSET = 2;

    localparam int DIVD_W    = 26;
    localparam int DIVS_W    = 17;
    localparam int DIV_CNT_W = $clog2(DIVD_W + 1);
    localparam int PRESS_W   = 10;
    localparam int TOTAL_W   = 12;
    localparam int SUM_W     = 16;
    localparam int LOC_W     = 13;
    localparam int SPEED_W   = 14;
    localparam int ACCEL_W   = 15;
    localparam int CNT_W     = 3;
    localparam int IDX_W     = $clog2(CHANNELS);
    localparam int TIME_W    = 32;

    localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(4);

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_CHANGED  = 2'd2,
        EV_RELEASED = 2'd3
    } event_kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIVA,
        S_SCALE,
        S_DIVB,
        S_MERGE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               start_a;
        logic               capture;
        logic               start_b;
        logic [TOTAL_W-1:0] total;
    } lane_cmd_t;

    typedef struct packed {
        logic               busy;
        logic [PRESS_W-1:0] raw;
        logic [PRESS_W-1:0] norm;
        logic [PRESS_W-1:0] scaled;
    } lane_stat_t;

endpackage

/* rtl/tsp_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on tsp_pkg for operand widths.
`timescale 1ns / 1ps

module tsp_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tsp_pkg::DIVD_W-1:0]  dividend,
    input  logic [tsp_pkg::DIVS_W-1:0]  divisor,
    output logic                        busy,
    output logic [tsp_pkg::DIVD_W-1:0]  quotient
);

    logic [tsp_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [tsp_pkg::DIVD_W-1:0]    quo_reg, quo_next;
    logic [tsp_pkg::DIVS_W-1:0]    dvs_reg, dvs_next;
    logic [tsp_pkg::DIVS_W-1:0]    rem_reg, rem_next;
    logic [tsp_pkg::DIVS_W:0]      trial;
    logic [tsp_pkg::DIVS_W:0]      diff;
    logic                          fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[tsp_pkg::DIVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = trial >= {1'b0, dvs_reg};
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        rem_next = rem_reg;
        if (start)
        begin
            cnt_next = tsp_pkg::DIV_CNT_W'(tsp_pkg::DIVD_W);
            quo_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[tsp_pkg::DIVD_W-2:0], fits};
            rem_next = fits ? diff[tsp_pkg::DIVS_W-1:0] : trial[tsp_pkg::DIVS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

endmodule

/* rtl/tsp_lane.sv */
// One slider channel: raw and normalized pressure, then share of the total.
// Depends on tsp_pkg and tsp_div.
`timescale 1ns / 1ps

module tsp_lane (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [tsp_pkg::SAMPLE_BITS-1:0]  sample,
    input  logic [tsp_pkg::SAMPLE_BITS-1:0]  min_val,
    input  logic [tsp_pkg::SAMPLE_BITS-1:0]  max_val,
    input  tsp_pkg::lane_cmd_t               cmd,
    output tsp_pkg::lane_stat_t              stat
);

    logic [tsp_pkg::DIVD_W-1:0]  p_dividend, n_dividend;
    logic [tsp_pkg::DIVS_W-1:0]  p_divisor, n_divisor;
    logic [tsp_pkg::DIVD_W-1:0]  p_quo, n_quo;
    logic                        p_busy, n_busy;
    logic [tsp_pkg::SAMPLE_BITS-1:0] span, excess;
    logic                        below, inverted;
    logic [tsp_pkg::PRESS_W-1:0] raw_reg, norm_reg;
    logic [tsp_pkg::PRESS_W-1:0] raw_next, norm_next;

    function automatic logic [tsp_pkg::PRESS_W-1:0] invert(
        input logic [tsp_pkg::DIVD_W-1:0] q
    );
        logic [tsp_pkg::DIVD_W-1:0] s;
        s = tsp_pkg::DIVD_W'(tsp_pkg::SCALE);
        invert = (q < s) ? tsp_pkg::PRESS_W'(s - q) : '0;
    endfunction

    always_comb
    begin
        span     = max_val - min_val;
        excess   = sample - min_val;
        below    = sample < min_val;
        inverted = max_val < min_val;
        if (cmd.start_b)
        begin
            p_dividend = tsp_pkg::DIVD_W'(raw_reg) * tsp_pkg::DIVD_W'(tsp_pkg::SCALE);
            p_divisor  = tsp_pkg::DIVS_W'(cmd.total) + 1'b1;
        end
        else
        begin
            p_dividend = tsp_pkg::DIVD_W'(sample) * tsp_pkg::DIVD_W'(tsp_pkg::SCALE);
            p_divisor  = tsp_pkg::DIVS_W'(max_val) + 1'b1;
        end
        n_dividend = tsp_pkg::DIVD_W'(excess) * tsp_pkg::DIVD_W'(tsp_pkg::SCALE);
        n_divisor  = tsp_pkg::DIVS_W'(span) + 1'b1;
        raw_next   = raw_reg;
        norm_next  = norm_reg;
        if (cmd.capture)
        begin
            raw_next = invert(p_quo);
            if (below)
            begin
                norm_next = '0;
            end
            else if (inverted)
            begin
                norm_next = tsp_pkg::PRESS_W'(tsp_pkg::SCALE);
            end
            else
            begin
                norm_next = invert(n_quo);
            end
        end
    end

    tsp_div u_div_p (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_a | cmd.start_b),
        .dividend (p_dividend),
        .divisor  (p_divisor),
        .busy     (p_busy),
        .quotient (p_quo)
    );

    tsp_div u_div_n (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_a),
        .dividend (n_dividend),
        .divisor  (n_divisor),
        .busy     (n_busy),
        .quotient (n_quo)
    );

    always_ff @(posedge clk)
    begin
        raw_reg  <= raw_next;
        norm_reg <= norm_next;
    end

    assign stat.busy   = p_busy | n_busy;
    assign stat.raw    = raw_reg;
    assign stat.norm   = norm_reg;
    assign stat.scaled = p_quo[tsp_pkg::PRESS_W-1:0];

endmodule

/* rtl/tsp_merge.sv */
// Merge of lane results: pressure totals, strongest channel and centroid.
// Depends on tsp_pkg for lane status and widths.
`timescale 1ns / 1ps

module tsp_merge (
    input  tsp_pkg::lane_stat_t             stat [tsp_pkg::CHANNELS],
    input  logic [tsp_pkg::CNT_W-1:0]       used,
    output logic [tsp_pkg::TOTAL_W-1:0]     total,
    output logic [tsp_pkg::LOC_W-1:0]       loc
);

    logic [tsp_pkg::TOTAL_W-1:0] total_norm;
    logic [tsp_pkg::TOTAL_W-1:0] deficit;
    logic [tsp_pkg::SUM_W-1:0]   loc_raw, loc_norm, pick;
    logic [tsp_pkg::PRESS_W-1:0] best;
    logic [tsp_pkg::IDX_W-1:0]   strongest;
    logic                        short;

    always_comb
    begin
        total      = '0;
        total_norm = '0;
        loc_raw    = '0;
        loc_norm   = '0;
        best       = '0;
        strongest  = '0;
        for (int i = 0; i < tsp_pkg::CHANNELS; i++)
        begin
            if (i < int'(used))
            begin
                total      = total + tsp_pkg::TOTAL_W'(stat[i].raw);
                total_norm = total_norm + tsp_pkg::TOTAL_W'(stat[i].norm);
                loc_raw    = loc_raw + tsp_pkg::SUM_W'(i + tsp_pkg::WEIGHT_OFFSET)
                             * tsp_pkg::SUM_W'(stat[i].scaled);
                loc_norm   = loc_norm + tsp_pkg::SUM_W'(i + tsp_pkg::WEIGHT_OFFSET)
                             * tsp_pkg::SUM_W'(stat[i].norm);
                if (best < stat[i].scaled)
                begin
                    best      = stat[i].scaled;
                    strongest = tsp_pkg::IDX_W'(i);
                end
            end
        end
        short   = total_norm < tsp_pkg::TOTAL_W'(tsp_pkg::SCALE);
        deficit = tsp_pkg::TOTAL_W'(tsp_pkg::SCALE) - total_norm;
        if (short && strongest == '0)
        begin
            loc_norm = loc_norm + tsp_pkg::SUM_W'(deficit);
        end
        else if (short && strongest == tsp_pkg::IDX_W'(used - 1'b1))
        begin
            loc_norm = loc_norm + (tsp_pkg::SUM_W'(used) + tsp_pkg::SUM_W'(tsp_pkg::WEIGHT_OFFSET))
                       * tsp_pkg::SUM_W'(deficit);
        end
        else
        begin
            loc_norm = '0;
        end
        pick = (loc_norm != '0) ? loc_norm : loc_raw;
        loc  = (pick >= tsp_pkg::SUM_W'(tsp_pkg::SCALE))
               ? tsp_pkg::LOC_W'(pick - tsp_pkg::SUM_W'(tsp_pkg::SCALE)) : '0;
    end

endmodule

/* rtl/touch_slider_position_tracker.sv */
// Top level of the touch slider position tracker: control, lanes and state.
// Depends on tsp_pkg, tsp_lane (with tsp_div) and tsp_merge.
`timescale 1ns / 1ps

// Usage:
// An input beat (in_valid/in_ready) carries one press or release event with a
// timestamp, packed per-channel samples, calibrated minima and maxima and the
// active mask. Each input beat yields exactly one output beat (out_valid/
// out_ready) with event kind, pressed flag, location, speed and acceleration.
// cfg_wr_en/cfg_wr_data write the channel count; the user must write it only while
// the block is idle, which the block itself does not enforce. A press steps through
// S_LOAD, S_DIVA, S_SCALE, S_DIVB and S_MERGE to S_DONE, running two passes of the
// bit-serial divider in every lane (pressures, then share of the total). A release
// or a repeated timestamp goes from S_LOAD straight to S_DONE.
// One event is in flight at a time; in_ready is high only when idle, so the
// next beat is taken in the cycle after a result is finished at the earliest.
// The output register holds a finished beat while the next event is taken;
// a stalled receiver holds the following result in its final state.
// Reset clears the tracking state, the output valid and sets the channel
// count to four.

module touch_slider_position_tracker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [tsp_pkg::CNT_W-1:0]             cfg_wr_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  mode,
    input  logic [tsp_pkg::TIME_W-1:0]            event_time,
    input  logic [tsp_pkg::CHANNELS*tsp_pkg::LANE_W-1:0] sample_values,
    input  logic [tsp_pkg::CHANNELS*tsp_pkg::LANE_W-1:0] min_values,
    input  logic [tsp_pkg::CHANNELS*tsp_pkg::LANE_W-1:0] max_values,
    input  logic [tsp_pkg::CHANNELS-1:0]          active_mask,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [1:0]                            event_kind,
    output logic                                  is_pressed,
    output logic [tsp_pkg::LOC_W-1:0]             location,
    output logic signed [tsp_pkg::SPEED_W-1:0]    speed,
    output logic signed [tsp_pkg::ACCEL_W-1:0]    acceleration
);

    tsp_pkg::state_t state_reg, state_next;
    logic [tsp_pkg::CNT_W-1:0] cfg_reg;
    logic [tsp_pkg::CNT_W-1:0] used;

    logic                                          mode_reg;
    logic [tsp_pkg::TIME_W-1:0]                    time_reg;
    logic [tsp_pkg::CHANNELS*tsp_pkg::LANE_W-1:0]  smp_reg, min_reg, max_reg;
    logic [tsp_pkg::CHANNELS-1:0]                  act_reg;

    logic [tsp_pkg::TIME_W-1:0]  last_time_reg, last_time_next;
    logic [tsp_pkg::LOC_W-1:0]   pos_reg, pos_next;
    logic [tsp_pkg::SPEED_W-1:0] vel_reg, vel_next;
    logic [tsp_pkg::ACCEL_W-1:0] acc_reg, acc_next;
    logic                        touched_reg, touched_next;
    logic [tsp_pkg::LOC_W-1:0]   loc_reg;

    logic                        out_valid_reg;
    tsp_pkg::event_kind_t        kind_reg, kind_next;
    logic                        commit;

    tsp_pkg::lane_cmd_t          cmd;
    tsp_pkg::lane_stat_t         stat [tsp_pkg::CHANNELS];
    logic [tsp_pkg::TOTAL_W-1:0] total;
    logic [tsp_pkg::LOC_W-1:0]   merged_loc;
    logic [tsp_pkg::CHANNELS-1:0] lane_mask;
    logic                        repeat_hit;
    logic [tsp_pkg::SPEED_W-1:0] spd;

    always_comb
    begin
        if (cfg_reg < tsp_pkg::CNT_W'(2))
        begin
            used = tsp_pkg::CNT_W'(2);
        end
        else if (cfg_reg > tsp_pkg::CNT_W'(tsp_pkg::CHANNELS))
        begin
            used = tsp_pkg::CNT_W'(tsp_pkg::CHANNELS);
        end
        else
        begin
            used = cfg_reg;
        end
        for (int i = 0; i < tsp_pkg::CHANNELS; i++)
        begin
            lane_mask[i] = i < int'(used);
        end
    end

    for (genvar g = 0; g < tsp_pkg::CHANNELS; g++)
    begin : g_lane
        tsp_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .sample  (smp_reg[g*tsp_pkg::LANE_W +: tsp_pkg::SAMPLE_BITS]),
            .min_val (min_reg[g*tsp_pkg::LANE_W +: tsp_pkg::SAMPLE_BITS]),
            .max_val (max_reg[g*tsp_pkg::LANE_W +: tsp_pkg::SAMPLE_BITS]),
            .cmd     (cmd),
            .stat    (stat[g])
        );
    end

    tsp_merge u_merge (
        .stat  (stat),
        .used  (used),
        .total (total),
        .loc   (merged_loc)
    );

    assign repeat_hit = time_reg == last_time_reg;
    assign in_ready   = state_reg == tsp_pkg::S_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        cmd.start_a    = 1'b0;
        cmd.capture    = 1'b0;
        cmd.start_b    = 1'b0;
        cmd.total      = total;
        commit         = 1'b0;
        last_time_next = last_time_reg;
        pos_next       = pos_reg;
        vel_next       = vel_reg;
        acc_next       = acc_reg;
        touched_next   = touched_reg;
        kind_next      = tsp_pkg::EV_NONE;
        spd            = '0;
        case (state_reg)
            tsp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tsp_pkg::S_LOAD;
                end
            end
            tsp_pkg::S_LOAD:
            begin
                if (repeat_hit || mode_reg)
                begin
                    state_next = tsp_pkg::S_DONE;
                end
                else
                begin
                    cmd.start_a = 1'b1;
                    state_next  = tsp_pkg::S_DIVA;
                end
            end
            tsp_pkg::S_DIVA:
            begin
                if (!stat[0].busy)
                begin
                    cmd.capture = 1'b1;
                    state_next  = tsp_pkg::S_SCALE;
                end
            end
            tsp_pkg::S_SCALE:
            begin
                cmd.start_b = 1'b1;
                state_next  = tsp_pkg::S_DIVB;
            end
            tsp_pkg::S_DIVB:
            begin
                if (!stat[0].busy)
                begin
                    state_next = tsp_pkg::S_MERGE;
                end
            end
            tsp_pkg::S_MERGE:
            begin
                state_next = tsp_pkg::S_DONE;
            end
            tsp_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    commit     = 1'b1;
                    state_next = tsp_pkg::S_IDLE;
                    if (!repeat_hit)
                    begin
                        last_time_next = time_reg;
                        if (!mode_reg)
                        begin
                            if (loc_reg != pos_reg)
                            begin
                                if (pos_reg != '0)
                                begin
                                    spd = tsp_pkg::SPEED_W'({1'b0, loc_reg})
                                          - tsp_pkg::SPEED_W'({1'b0, pos_reg});
                                end
                                acc_next = {spd[tsp_pkg::SPEED_W-1], spd}
                                           - {vel_reg[tsp_pkg::SPEED_W-1], vel_reg};
                                vel_next = spd;
                                kind_next = tsp_pkg::EV_CHANGED;
                            end
                            if (!touched_reg)
                            begin
                                kind_next = tsp_pkg::EV_PRESSED;
                            end
                            pos_next     = loc_reg;
                            touched_next = 1'b1;
                        end
                        else if ((act_reg & lane_mask) == '0)
                        begin
                            touched_next = 1'b0;
                            pos_next     = '0;
                            kind_next    = tsp_pkg::EV_RELEASED;
                        end
                    end
                end
            end
            default:
            begin
                state_next = tsp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsp_pkg::S_IDLE;
            cfg_reg       <= tsp_pkg::CFG_RESET;
            last_time_reg <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            acc_reg       <= '0;
            touched_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            kind_reg      <= tsp_pkg::EV_NONE;
        end
        else
        begin
            state_reg     <= state_next;
            last_time_reg <= last_time_next;
            pos_reg       <= pos_next;
            vel_reg       <= vel_next;
            acc_reg       <= acc_next;
            touched_reg   <= touched_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                kind_reg      <= kind_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mode_reg <= mode;
            time_reg <= event_time;
            smp_reg  <= sample_values;
            min_reg  <= min_values;
            max_reg  <= max_values;
            act_reg  <= active_mask;
        end
        if (state_reg == tsp_pkg::S_MERGE)
        begin
            loc_reg <= merged_loc;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign is_pressed   = touched_reg;
    assign location     = pos_reg;
    assign speed        = vel_reg;
    assign acceleration = acc_reg;

    a_idle_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == tsp_pkg::S_LOAD)
        else $error("accepted beat did not start processing");

    a_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        stat[0].busy |-> (state_reg == tsp_pkg::S_DIVA || state_reg == tsp_pkg::S_DIVB))
        else $error("lane divider running outside a divide state");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        !touched_reg |-> pos_reg == '0)
        else $error("location held while slider not pressed");

    a_commit_fills: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> out_valid_reg && state_reg == tsp_pkg::S_IDLE)
        else $error("finished event not presented");

endmodule

/* test/tb.sv */
// Self-checking testbench for touch_slider_position_tracker.
// Depends on rtl/tsp_pkg.sv and the RTL top; a built-in slider predictor, or a
// typed expectation on some directed rows, checks every output beat.
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT = 6000;
    localparam int PHASE_ITEMS = 220;

    typedef struct packed {
        logic [1:0]                         kind;
        logic                               pressed;
        logic [tsp_pkg::LOC_W-1:0]          loc;
        logic signed [tsp_pkg::SPEED_W-1:0] spd;
        logic signed [tsp_pkg::ACCEL_W-1:0] acc;
    } slider_result_t;

    typedef struct packed {
        logic                          mode;
        logic [tsp_pkg::TIME_W-1:0]    t;
        logic [63:0]                   smp;
        logic [63:0]                   mn;
        logic [63:0]                   mx;
        logic [tsp_pkg::CHANNELS-1:0]  mask;
        logic                          typed;
        slider_result_t                want;
    } slider_row_t;

    logic clk, rst_n, cfg_wr_en, in_valid, in_ready, out_valid, out_ready;
    logic [tsp_pkg::CNT_W-1:0] cfg_wr_data;
    logic mode;
    logic [tsp_pkg::TIME_W-1:0] event_time;
    logic [63:0] sample_values, min_values, max_values;
    logic [tsp_pkg::CHANNELS-1:0] active_mask;
    logic [1:0] event_kind;
    logic is_pressed;
    logic [tsp_pkg::LOC_W-1:0] location;
    logic signed [tsp_pkg::SPEED_W-1:0] speed;
    logic signed [tsp_pkg::ACCEL_W-1:0] acceleration;

    touch_slider_position_tracker dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .event_time(event_time), .sample_values(sample_values),
        .min_values(min_values), .max_values(max_values),
        .active_mask(active_mask),
        .out_valid(out_valid), .out_ready(out_ready),
        .event_kind(event_kind), .is_pressed(is_pressed), .location(location),
        .speed(speed), .acceleration(acceleration)
    );

    // tracker copy
    logic [tsp_pkg::CNT_W-1:0] chan_cfg;
    logic [tsp_pkg::TIME_W-1:0] prev_time;
    int unsigned prev_loc;
    int prev_speed, prev_accel;
    logic touching;

    slider_result_t pending_results[$];
    int errors, checked, n_items, n_press, n_release, n_repeat;
    int idle_cycles;
    bit calm;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int unsigned lane_of(logic [63:0] p, int i);
        return int'(p[i*16 +: 16]);
    endfunction

    function automatic slider_result_t track_event(logic md, logic [tsp_pkg::TIME_W-1:0] t,
            logic [63:0] smp, logic [63:0] mn, logic [63:0] mx,
            logic [tsp_pkg::CHANNELS-1:0] mask);
        int unsigned n, v, lo, hi, q, total, tnorm, loc, locn, strongest;
        int unsigned raw[4];
        int unsigned nrm[4];
        int spd;
        logic changed;
        slider_result_t r;
        r.kind = tsp_pkg::EV_NONE;
        changed = 1'b0;
        if (t != prev_time)
        begin
            n = chan_cfg;
            if (n < 2) n = 2;
            if (n > tsp_pkg::CHANNELS) n = tsp_pkg::CHANNELS;
            if (md == 1'b0)
            begin
                total = 0; tnorm = 0; loc = 0; locn = 0; strongest = 0;
                for (int i = 0; i < n; i++)
                begin
                    v = lane_of(smp, i); lo = lane_of(mn, i); hi = lane_of(mx, i);
                    q = int'((longint'(v) * tsp_pkg::SCALE) / (longint'(hi) + 1));
                    raw[i] = (q < tsp_pkg::SCALE) ? tsp_pkg::SCALE - q : 0;
                    if (v < lo) nrm[i] = 0;
                    else if (hi < lo) nrm[i] = tsp_pkg::SCALE;
                    else
                    begin
                        q = int'((longint'(v - lo) * tsp_pkg::SCALE) / (longint'(hi - lo) + 1));
                        nrm[i] = (q < tsp_pkg::SCALE) ? tsp_pkg::SCALE - q : 0;
                    end
                    total += raw[i];
                    tnorm += nrm[i];
                end
                for (int i = 0; i < n; i++)
                begin
                    raw[i] = raw[i] * tsp_pkg::SCALE / (total + 1);
                    loc += (i + tsp_pkg::WEIGHT_OFFSET) * raw[i];
                    locn += (i + tsp_pkg::WEIGHT_OFFSET) * nrm[i];
                    if (raw[strongest] < raw[i]) strongest = i;
                end
                if (strongest == 0 && tnorm < tsp_pkg::SCALE) locn += tsp_pkg::SCALE - tnorm;
                else if (strongest == n - 1 && tnorm < tsp_pkg::SCALE)
                    locn += (n + tsp_pkg::WEIGHT_OFFSET) * (tsp_pkg::SCALE - tnorm);
                else locn = 0;
                if (locn > 0) loc = locn;
                loc = (loc >= tsp_pkg::SCALE) ? loc - tsp_pkg::SCALE : 0;
                loc &= 32'h1FFF;
                if (loc != prev_loc)
                begin
                    spd = (prev_loc != 0) ? int'(loc) - int'(prev_loc) : 0;
                    prev_accel = spd - prev_speed;
                    prev_speed = spd;
                    changed = 1'b1;
                end
                prev_loc = loc;
                if (!touching) r.kind = tsp_pkg::EV_PRESSED;
                else if (changed) r.kind = tsp_pkg::EV_CHANGED;
                touching = 1'b1;
                n_press++;
            end
            else
            begin
                if ((int'(mask) & ((1 << n) - 1)) == 0)
                begin
                    touching = 1'b0;
                    prev_loc = 0;
                    r.kind = tsp_pkg::EV_RELEASED;
                end
                n_release++;
            end
            prev_time = t;
        end
        else n_repeat++;
        r.pressed = touching;
        r.loc = tsp_pkg::LOC_W'(prev_loc);
        r.spd = tsp_pkg::SPEED_W'(prev_speed);
        r.acc = tsp_pkg::ACCEL_W'(prev_accel);
        return r;
    endfunction

    task automatic send_event(slider_row_t row, int gap);
        slider_result_t r;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= row.mode;
        event_time <= row.t;
        sample_values <= row.smp;
        min_values <= row.mn;
        max_values <= row.mx;
        active_mask <= row.mask;
        do @(posedge clk); while (!in_ready);
        r = track_event(row.mode, row.t, row.smp, row.mn, row.mx, row.mask);
        pending_results.push_back(row.typed ? row.want : r);
        n_items++;
    endtask

    task automatic drain_and_write(logic [tsp_pkg::CNT_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results.size() == 0);
        repeat (8) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        chan_cfg = value;
    endtask

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 12);
    endfunction

    // output side: stall at random
    initial
    begin
        int g;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = draw_gap();
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        slider_result_t w;
        if (rst_n && out_valid && out_ready)
        begin
            checked++;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected output beat at %0t", $realtime);
            end
            else
            begin
                w = pending_results.pop_front();
                if (w.kind !== event_kind || w.pressed !== is_pressed || w.loc !== location
                        || w.spd !== speed || w.acc !== acceleration)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("mismatch at %0t: exp kind %0d pr %0d loc %0d spd %0d acc %0d",
                                 $realtime, w.kind, w.pressed, w.loc, w.spd, w.acc);
                        $display("    got kind %0d pr %0d loc %0d spd %0d acc %0d",
                                 event_kind, is_pressed, location, speed, acceleration);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", LIMIT);
                $display("** touch_slider_position_tracker: FAILED **");
                $finish;
            end
        end
    end

    function automatic logic [63:0] pack4(int a, int b, int c, int d);
        return {16'(d), 16'(c), 16'(b), 16'(a)};
    endfunction

    function automatic slider_row_t plain_row(logic md, logic [31:0] t, logic [63:0] s,
            logic [63:0] lo, logic [63:0] hi, logic [3:0] mask);
        slider_row_t row;
        row = '0;
        row.mode = md; row.t = t; row.smp = s; row.mn = lo; row.mx = hi; row.mask = mask;
        return row;
    endfunction

    initial
    begin
        slider_row_t rows[$];
        slider_row_t row;
        logic [tsp_pkg::CNT_W-1:0] cfg_list[$];
        logic [31:0] tnow;
        int finger, d, mx, mn, presses, k;
        logic [63:0] s, lo, hi;

        rst_n = 1'b0; cfg_wr_en = 1'b0; cfg_wr_data = '0; in_valid = 1'b0;
        mode = 1'b0; event_time = '0; sample_values = '0; min_values = '0;
        max_values = '0; active_mask = '0;
        chan_cfg = tsp_pkg::CFG_RESET; prev_time = '0; prev_loc = 0; prev_speed = 0;
        prev_accel = 0; touching = 1'b0;
        errors = 0; checked = 0; n_items = 0; n_press = 0; n_release = 0; n_repeat = 0;
        idle_cycles = 0; calm = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        row = plain_row(1'b0, 0, pack4(100, 200, 300, 400), '0, '1, 4'h0);
        row.typed = 1'b1; row.want = '{tsp_pkg::EV_NONE, 1'b0, '0, '0, '0};
        rows.push_back(row);
        row = plain_row(1'b1, 1, '0, '0, '1, 4'h0);
        row.typed = 1'b1; row.want = '{tsp_pkg::EV_RELEASED, 1'b0, '0, '0, '0};
        rows.push_back(row);
        rows.push_back(plain_row(1'b0, 2, '1, '0, '1, 4'h0));
        rows.push_back(plain_row(1'b0, 3, '0, '0, '1, 4'hF));
        rows.push_back(plain_row(1'b0, 3, pack4(5, 5, 5, 5), '0, '1, 4'hF));
        rows.push_back(plain_row(1'b0, 4, pack4(50, 3000, 3000, 3000),
                                 pack4(100, 100, 100, 100), pack4(4000, 4000, 4000, 4000), 4'h1));
        rows.push_back(plain_row(1'b0, 5, pack4(3000, 3000, 3000, 20),
                                 pack4(100, 100, 100, 100), pack4(4000, 4000, 4000, 4000), 4'h8));
        rows.push_back(plain_row(1'b0, 6, pack4(600, 700, 800, 900),
                                 pack4(500, 500, 500, 500), pack4(100, 100, 100, 100), 4'hF));
        rows.push_back(plain_row(1'b0, 7, pack4(1000, 1000, 3000, 3000),
                                 pack4(0, 0, 0, 0), pack4(4000, 4000, 4000, 4000), 4'h3));
        rows.push_back(plain_row(1'b0, 8, pack4(3000, 1000, 1000, 3000),
                                 pack4(0, 0, 0, 0), pack4(4000, 4000, 4000, 4000), 4'h6));
        rows.push_back(plain_row(1'b1, 9, '0, '0, '0, 4'hF));
        rows.push_back(plain_row(1'b1, 10, '0, '0, '0, 4'h0));
        rows.push_back(plain_row(1'b0, 32'hFFFF_FFFF, '1, '1, '1, 4'hF));
        rows.push_back(plain_row(1'b0, 32'hAAAA_5555, '0, '1, '0, 4'hA));
        rows.push_back(plain_row(1'b0, 32'h5555_AAAA, 64'h8000_4000_2000_1000, '0, '1, 4'h5));
        rows.push_back(plain_row(1'b1, 0, '1, '1, '1, 4'h0));
        foreach (rows[i]) send_event(rows[i], draw_gap());

        cfg_list = '{3'd2, 3'd3, 3'd0, 3'd1, 3'd5, 3'd7, 3'd6, 3'd4};
        tnow = 32'd100;
        foreach (cfg_list[p])
        begin
            drain_and_write(cfg_list[p]);
            calm = (p % 3 == 2);
            k = 0;
            while (k < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    // noise: anything goes
                    row = plain_row(1'($urandom_range(0, 1)),
                                    ($urandom_range(0, 2) == 0) ? tnow : $urandom(),
                                    {$urandom(), $urandom()}, {$urandom(), $urandom()},
                                    {$urandom(), $urandom()}, 4'($urandom()));
                    tnow = row.t;
                    send_event(row, draw_gap());
                    k++;
                end
                else
                begin
                    // gesture: finger slides along, then lifts
                    finger = $urandom_range(0, 300);
                    presses = $urandom_range(1, 8);
                    for (int j = 0; j < presses; j++)
                    begin
                        for (int c = 0; c < 4; c++)
                        begin
                            mx = $urandom_range(2000, 65535);
                            mn = $urandom_range(0, mx / 4);
                            d = finger - c * 100;
                            if (d < 0) d = -d;
                            d = (d > 100) ? 100 : d;
                            lo[c*16 +: 16] = 16'(mn);
                            hi[c*16 +: 16] = 16'(mx);
                            s[c*16 +: 16] = 16'(mn + (mx - mn) * d / 100
                                                 - $urandom_range(0, mn / 8 + 1));
                        end
                        tnow += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
                        send_event(plain_row(1'b0, tnow, s, lo, hi, 4'($urandom())),
                                   draw_gap());
                        finger += $urandom_range(0, 60) - 30;
                        if (finger < 0) finger = 0;
                        k++;
                    end
                    if ($urandom_range(0, 3) == 0)
                    begin
                        tnow += 1;
                        send_event(plain_row(1'b1, tnow, s, lo, hi, 4'hF), draw_gap());
                        k++;
                    end
                    tnow += 1;
                    send_event(plain_row(1'b1, tnow, s, lo, hi,
                                         4'($urandom_range(0, 1) << 3)), draw_gap());
                    k++;
                end
            end
        end

        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (80) @(posedge clk);
        if (pending_results.size() != 0) errors++;
        $display("Sent %0d events (%0d press, %0d release, %0d repeated timestamps),",
                 n_items, n_press, n_release, n_repeat);
        $display("checked %0d results over eight channel-count settings, %0d errors.",
                 checked, errors);
        if (errors == 0)
            $display("** touch_slider_position_tracker: PASSED **");
        else
            $display("** touch_slider_position_tracker: FAILED **");
        $finish;
    end

endmodule
